@@ hw/rtl/distinct_point_interval_match_top_assert.svh @@
// Assertion macros for the interval match block.
`ifndef DISTINCT_POINT_INTERVAL_MATCH_TOP_ASSERT_SVH
`define DISTINCT_POINT_INTERVAL_MATCH_TOP_ASSERT_SVH

`ifndef ASSERT_OFF

`define DPIM_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("dpim: assertion failed");

`define DPIM_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dpim: implication failed");

`else

`define DPIM_ASSERT(lbl, prop)

`define DPIM_ASSERT_IMP(lbl, ante, cons)

`endif

`endif

@@ hw/rtl/dpim_pkg.sv @@
package dpim_pkg;

    localparam logic [1:0] KIND_VALUE = 2'd0;
    localparam logic [1:0] KIND_RANGE = 2'd1;
    localparam logic [1:0] KIND_EVAL  = 2'd2;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [15:0] value_minutes;
        logic signed [15:0] range_start;
        logic signed [15:0] range_end;
    } in_item_t;

    typedef struct packed {
        logic matched;
        logic status;
    } out_item_t;

    typedef struct packed {
        logic signed [15:0] lo;
        logic signed [15:0] hi;
    } span_t;

    typedef struct packed {
        logic load_value;
        logic load_range;
        logic init_eval;
        logic scan_start;
        logic scan_step;
        logic scan_range;
        logic commit_range;
        logic commit_value;
        logic clear_all;
    } dp_cmd_t;

    typedef struct packed {
        logic ovf;
        logic ranges_empty;
        logic fewer_values;
        logic scan_end;
        logic pick_found;
        logic best_found;
        logic last_round;
    } dp_stat_t;

endpackage

@@ hw/rtl/dpim_datapath.sv @@
`include "distinct_point_interval_match_top_assert.svh"

module dpim_datapath #(
    parameter int MAX_VALUES = 16,
    parameter int MAX_RANGES = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  dpim_pkg::in_item_t req,
    input  dpim_pkg::dp_cmd_t  cmd,
    output dpim_pkg::dp_stat_t stat
);

    localparam int VIW = (MAX_VALUES > 1) ? $clog2(MAX_VALUES) : 1;
    localparam int RIW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
    localparam int VCW = $clog2(MAX_VALUES + 1);
    localparam int RCW = $clog2(MAX_RANGES + 1);
    localparam int SCW = (VCW > RCW) ? VCW : RCW;

    logic signed [15:0] vmem [MAX_VALUES];
    dpim_pkg::span_t    rmem [MAX_RANGES];

    logic signed [15:0] vrd_reg;
    dpim_pkg::span_t    rrd_reg;

    logic [VCW-1:0]        vcnt_reg, vcnt_next;
    logic [RCW-1:0]        rcnt_reg, rcnt_next;
    logic                  ovf_reg, ovf_next;
    logic [MAX_RANGES-1:0] done_reg, done_next;
    logic [MAX_VALUES-1:0] used_reg, used_next;
    logic [RCW-1:0]        round_reg, round_next;
    logic [SCW-1:0]        idx_reg, idx_next;
    logic [SCW-1:0]        rd_idx_reg, rd_idx_next;
    logic                  rd_vld_reg, rd_vld_next;
    logic                  pick_found_reg, pick_found_next;
    logic                  best_found_reg, best_found_next;

    logic [RIW-1:0]     pick_idx_reg;
    logic signed [15:0] pick_lo_reg;
    logic signed [15:0] pick_hi_reg;
    logic [VIW-1:0]     best_idx_reg;
    logic signed [15:0] best_val_reg;

    logic           vfull;
    logic           rfull;
    logic [SCW-1:0] limit;
    logic           issue;
    logic           rng_hit;
    logic           val_hit;

    assign vfull = (vcnt_reg == VCW'(MAX_VALUES));
    assign rfull = (rcnt_reg == RCW'(MAX_RANGES));
    assign limit = cmd.scan_range ? SCW'(rcnt_reg) : SCW'(vcnt_reg);
    assign issue = cmd.scan_step && !cmd.scan_start && (idx_reg < limit);

    assign rng_hit = rd_vld_reg && cmd.scan_range
                   && !done_reg[rd_idx_reg[RIW-1:0]]
                   && (!pick_found_reg || (rrd_reg.hi < pick_hi_reg));

    assign val_hit = rd_vld_reg && !cmd.scan_range
                   && !used_reg[rd_idx_reg[VIW-1:0]]
                   && (vrd_reg >= pick_lo_reg) && (vrd_reg < pick_hi_reg)
                   && (!best_found_reg || (vrd_reg < best_val_reg));

    // stores and their read ports
    always_ff @(posedge clk)
    begin
        if (cmd.load_value && !vfull)
        begin
            vmem[vcnt_reg[VIW-1:0]] <= req.value_minutes;
        end
        if (cmd.load_range && !rfull)
        begin
            rmem[rcnt_reg[RIW-1:0]] <= '{lo: req.range_start, hi: req.range_end};
        end
        if (issue && !cmd.scan_range)
        begin
            vrd_reg <= vmem[idx_reg[VIW-1:0]];
        end
        if (issue && cmd.scan_range)
        begin
            rrd_reg <= rmem[idx_reg[RIW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rng_hit)
        begin
            pick_idx_reg <= rd_idx_reg[RIW-1:0];
            pick_lo_reg  <= rrd_reg.lo;
            pick_hi_reg  <= rrd_reg.hi;
        end
        if (val_hit)
        begin
            best_idx_reg <= rd_idx_reg[VIW-1:0];
            best_val_reg <= vrd_reg;
        end
    end

    always_comb
    begin
        vcnt_next       = vcnt_reg;
        rcnt_next       = rcnt_reg;
        ovf_next        = ovf_reg;
        done_next       = done_reg;
        used_next       = used_reg;
        round_next      = round_reg;
        idx_next        = idx_reg;
        rd_idx_next     = rd_idx_reg;
        rd_vld_next     = rd_vld_reg;
        pick_found_next = pick_found_reg;
        best_found_next = best_found_reg;

        if (cmd.load_value)
        begin
            if (vfull)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                vcnt_next = vcnt_reg + VCW'(1);
            end
        end
        if (cmd.load_range)
        begin
            if (rfull)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                rcnt_next = rcnt_reg + RCW'(1);
            end
        end
        if (cmd.init_eval)
        begin
            done_next  = '0;
            used_next  = '0;
            round_next = '0;
        end
        if (cmd.scan_start)
        begin
            idx_next        = '0;
            rd_vld_next     = 1'b0;
            pick_found_next = 1'b0;
            best_found_next = 1'b0;
        end
        else if (cmd.scan_step)
        begin
            if (issue)
            begin
                idx_next    = idx_reg + SCW'(1);
                rd_idx_next = idx_reg;
                rd_vld_next = 1'b1;
            end
            else
            begin
                rd_vld_next = 1'b0;
            end
            if (rng_hit)
            begin
                pick_found_next = 1'b1;
            end
            if (val_hit)
            begin
                best_found_next = 1'b1;
            end
        end
        if (cmd.commit_range)
        begin
            done_next[pick_idx_reg] = 1'b1;
        end
        if (cmd.commit_value)
        begin
            used_next[best_idx_reg] = 1'b1;
            round_next = round_reg + RCW'(1);
        end
        if (cmd.clear_all)
        begin
            vcnt_next  = '0;
            rcnt_next  = '0;
            ovf_next   = 1'b0;
            done_next  = '0;
            used_next  = '0;
            round_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcnt_reg       <= '0;
            rcnt_reg       <= '0;
            ovf_reg        <= 1'b0;
            done_reg       <= '0;
            used_reg       <= '0;
            round_reg      <= '0;
            idx_reg        <= '0;
            rd_idx_reg     <= '0;
            rd_vld_reg     <= 1'b0;
            pick_found_reg <= 1'b0;
            best_found_reg <= 1'b0;
        end
        else
        begin
            vcnt_reg       <= vcnt_next;
            rcnt_reg       <= rcnt_next;
            ovf_reg        <= ovf_next;
            done_reg       <= done_next;
            used_reg       <= used_next;
            round_reg      <= round_next;
            idx_reg        <= idx_next;
            rd_idx_reg     <= rd_idx_next;
            rd_vld_reg     <= rd_vld_next;
            pick_found_reg <= pick_found_next;
            best_found_reg <= best_found_next;
        end
    end

    always_comb
    begin
        stat.ovf          = ovf_reg;
        stat.ranges_empty = (rcnt_reg == '0);
        stat.fewer_values = (SCW'(vcnt_reg) < SCW'(rcnt_reg));
        stat.scan_end     = (idx_reg == limit) && !rd_vld_reg;
        stat.pick_found   = pick_found_reg;
        stat.best_found   = best_found_reg;
        stat.last_round   = ((round_reg + RCW'(1)) == rcnt_reg);
    end

    `DPIM_ASSERT(a_cnt_bound, (vcnt_reg <= VCW'(MAX_VALUES)) && (rcnt_reg <= RCW'(MAX_RANGES)))
    `DPIM_ASSERT(a_used_round, $countones(used_reg) == int'(round_reg))
    `DPIM_ASSERT(a_done_round, ($countones(done_reg) == int'(round_reg)) || ($countones(done_reg) == int'(round_reg) + 1))

endmodule

@@ hw/rtl/dpim_ctrl.sv @@
`include "distinct_point_interval_match_top_assert.svh"

module dpim_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  logic [1:0]          req_kind,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output dpim_pkg::out_item_t rsp,
    output dpim_pkg::dp_cmd_t   cmd,
    input  dpim_pkg::dp_stat_t  stat
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_RSCAN  = 4'b0010,
        ST_VSCAN  = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t              state_reg, state_next;
    logic                match_reg, match_next;
    logic                rsp_valid_reg, rsp_valid_next;
    dpim_pkg::out_item_t rsp_reg, rsp_next;
    logic                accept;

    assign req_ready = (state_reg == ST_IDLE);
    assign accept    = req_valid && req_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        state_next     = state_reg;
        match_next     = match_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        cmd            = '0;
        cmd.scan_step  = (state_reg == ST_RSCAN) || (state_reg == ST_VSCAN);
        cmd.scan_range = (state_reg == ST_RSCAN);

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (req_kind)
                        dpim_pkg::KIND_VALUE: cmd.load_value = 1'b1;
                        dpim_pkg::KIND_RANGE: cmd.load_range = 1'b1;
                        dpim_pkg::KIND_EVAL:
                        begin
                            if (stat.ovf || stat.ranges_empty || stat.fewer_values)
                            begin
                                match_next = !stat.ovf && stat.ranges_empty;
                                state_next = ST_FINISH;
                            end
                            else
                            begin
                                cmd.init_eval  = 1'b1;
                                cmd.scan_start = 1'b1;
                                state_next     = ST_RSCAN;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_RSCAN:
            begin
                if (stat.scan_end)
                begin
                    cmd.commit_range = 1'b1;
                    cmd.scan_start   = 1'b1;
                    state_next       = ST_VSCAN;
                end
            end
            ST_VSCAN:
            begin
                if (stat.scan_end)
                begin
                    if (!stat.best_found)
                    begin
                        match_next = 1'b0;
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        cmd.commit_value = 1'b1;
                        if (stat.last_round)
                        begin
                            match_next = 1'b1;
                            state_next = ST_FINISH;
                        end
                        else
                        begin
                            cmd.scan_start = 1'b1;
                            state_next     = ST_RSCAN;
                        end
                    end
                end
            end
            ST_FINISH:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next   = 1'b1;
                    rsp_next.matched = match_reg;
                    rsp_next.status  = stat.ovf;
                    cmd.clear_all    = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            match_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            match_reg     <= match_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    // an unfinished range always exists while rounds remain
    `DPIM_ASSERT_IMP(a_pick_found, (state_reg == ST_RSCAN) && stat.scan_end, stat.pick_found)

endmodule

@@ hw/rtl/distinct_point_interval_match_top.sv @@
// Distinct point to interval matcher.
// Input channel req/req_valid/req_ready carries one item: kind 0 stores
// value_minutes, kind 1 stores the range [range_start, range_end), kind 2
// evaluates; kind 3 is ignored. Output channel rsp/rsp_valid/rsp_ready
// carries one item per evaluate: matched and status (1 = a load was dropped
// because a store was full, which also forces matched to 0).
// Load items give no result.
// An evaluate walks the stores with one shared scan counter: for each of R
// stored ranges it scans the range store for the unfinished range with the
// smallest end, then the value store for the smallest free value inside
// it. An evaluate ends early on the first range left without a value, and
// goes straight to its result when ranges are empty, values are fewer, or
// a load overflowed.
// req_ready is low for the whole walk; both stores clear when it ends.
// The result sits in an output register, so loads are still taken while
// the receiver stalls; a following evaluate finishes its walk and then
// waits for the register to free up.
// Reset empties both stores and clears the overflow flag; no clearing pass.
module distinct_point_interval_match_top #(
    parameter int MAX_VALUES = 16,
    parameter int MAX_RANGES = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  dpim_pkg::in_item_t  req,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output dpim_pkg::out_item_t rsp
);

    dpim_pkg::dp_cmd_t  cmd;
    dpim_pkg::dp_stat_t stat;

    dpim_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_kind  (req.kind),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cmd       (cmd),
        .stat      (stat)
    );

    dpim_datapath #(
        .MAX_VALUES (MAX_VALUES),
        .MAX_RANGES (MAX_RANGES)
    ) u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cmd   (cmd),
        .stat  (stat)
    );

endmodule

@@ tb/distinct_point_interval_match_top_test.sv @@
`timescale 1ns / 100ps

class match_checker;
    localparam int MAX_VALUES = 16;
    localparam int MAX_RANGES = 8;

    logic signed [15:0] value_mem [MAX_VALUES];
    logic signed [15:0] lo_mem [MAX_RANGES];
    logic signed [15:0] hi_mem [MAX_RANGES];
    int n_values;
    int n_ranges;
    bit overflowed;
    dpim_pkg::out_item_t expected_answers [$];
    int errors;
    int evals;
    int match_count;
    int overflows;

    function new();
        n_values = 0;
        n_ranges = 0;
        overflowed = 1'b0;
        errors = 0;
        evals = 0;
        match_count = 0;
        overflows = 0;
    endfunction

    task report(string what);
        $display("mismatch: %s", what);
        errors++;
    endtask

    // earliest end first, each range takes the smallest free value inside it
    function bit greedy_fits();
        bit range_done [MAX_RANGES];
        bit value_taken [MAX_VALUES];
        int pick;
        int best;
        if (n_ranges == 0)
            return 1'b1;
        if (n_values < n_ranges)
            return 1'b0;
        foreach (range_done[k])
            range_done[k] = 1'b0;
        foreach (value_taken[v])
            value_taken[v] = 1'b0;
        for (int r = 0; r < n_ranges; r++)
        begin
            pick = -1;
            for (int k = 0; k < n_ranges; k++)
                if (!range_done[k] && (pick < 0 || hi_mem[k] < hi_mem[pick]))
                    pick = k;
            range_done[pick] = 1'b1;
            best = -1;
            for (int v = 0; v < n_values; v++)
                if (!value_taken[v] && value_mem[v] >= lo_mem[pick]
                    && value_mem[v] < hi_mem[pick]
                    && (best < 0 || value_mem[v] < value_mem[best]))
                    best = v;
            if (best < 0)
                return 1'b0;
            value_taken[best] = 1'b1;
        end
        return 1'b1;
    endfunction

    function void note_item(dpim_pkg::in_item_t it);
        dpim_pkg::out_item_t answer;
        case (it.kind)
            dpim_pkg::KIND_VALUE:
            begin
                if (n_values < MAX_VALUES)
                begin
                    value_mem[n_values] = it.value_minutes;
                    n_values++;
                end
                else
                    overflowed = 1'b1;
            end
            dpim_pkg::KIND_RANGE:
            begin
                if (n_ranges < MAX_RANGES)
                begin
                    lo_mem[n_ranges] = it.range_start;
                    hi_mem[n_ranges] = it.range_end;
                    n_ranges++;
                end
                else
                    overflowed = 1'b1;
            end
            dpim_pkg::KIND_EVAL:
            begin
                answer.matched = overflowed ? 1'b0 : greedy_fits();
                answer.status = overflowed;
                expected_answers.insert(expected_answers.size(), answer);
                evals++;
                match_count += answer.matched;
                overflows += overflowed;
                n_values = 0;
                n_ranges = 0;
                overflowed = 1'b0;
            end
            default:
            begin
            end
        endcase
    endfunction

    task check_result(dpim_pkg::out_item_t got);
        dpim_pkg::out_item_t want;
        if (expected_answers.size() == 0)
            report($sformatf("result with none outstanding: matched=%b status=%b",
                             got.matched, got.status));
        else
        begin
            want = expected_answers.pop_front();
            if (got.matched !== want.matched)
                report($sformatf("matched=%b, expected %b (evaluate %0d)",
                                 got.matched, want.matched, evals - expected_answers.size()));
            if (got.status !== want.status)
                report($sformatf("status=%b, expected %b (evaluate %0d)",
                                 got.status, want.status, evals - expected_answers.size()));
        end
    endtask
endclass

module distinct_point_interval_match_top_test;
    localparam logic [1:0] KIND_NONE = 2'd3;
    localparam int ITEM_TARGET = 2000;
    localparam int CALM_AFTER = 1700;
    localparam int HOLD_AFTER = 300;
    localparam int HOLD_CYCLES = 600;
    localparam int DRAIN_CYCLES = 300;
    localparam int CYCLE_LIMIT = 500000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    dpim_pkg::in_item_t req = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    dpim_pkg::out_item_t rsp;

    int item_count = 0;
    int cycle_count = 0;
    bit calm = 1'b0;
    bit hold_done = 1'b0;
    match_checker board = new();

    distinct_point_interval_match_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always #2 clk = ~clk;

    function automatic dpim_pkg::in_item_t make_item(logic [1:0] kind, int v, int lo, int hi);
        dpim_pkg::in_item_t it;
        it.kind = kind;
        it.value_minutes = 16'(v);
        it.range_start = 16'(lo);
        it.range_end = 16'(hi);
        return it;
    endfunction

    task automatic send_item(dpim_pkg::in_item_t it);
        int gap;
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 10);
            @(negedge clk);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        req_valid <= 1'b1;
        req <= it;
        do @(posedge clk); while (!req_ready);
        board.note_item(it);
        if (it.kind != KIND_NONE)
            item_count++;
    endtask

    // one store fill in random order, usually closed by an evaluate
    task automatic run_batch();
        dpim_pkg::in_item_t loads [$];
        dpim_pkg::in_item_t it;
        int nv;
        int nr;
        int base;
        int lo;
        bit wide;
        wide = ($urandom_range(0, 7) == 0);
        base = int'($urandom_range(0, 65535)) - 32768;
        nv = ($urandom_range(0, 11) == 0) ? $urandom_range(17, 19) : $urandom_range(0, 16);
        nr = ($urandom_range(0, 11) == 0) ? $urandom_range(9, 10) : $urandom_range(0, 8);
        repeat (nv)
        begin
            it.kind = dpim_pkg::KIND_VALUE;
            it.value_minutes = wide ? 16'($urandom) : 16'(base + int'($urandom_range(0, 30)));
            it.range_start = 16'($urandom);
            it.range_end = 16'($urandom);
            loads.insert($urandom_range(0, loads.size()), it);
        end
        repeat (nr)
        begin
            it.kind = dpim_pkg::KIND_RANGE;
            it.value_minutes = 16'($urandom);
            if (wide)
            begin
                it.range_start = 16'($urandom);
                it.range_end = 16'($urandom);
            end
            else
            begin
                lo = base + int'($urandom_range(0, 33)) - 3;
                it.range_start = 16'(lo);
                it.range_end = 16'(lo + int'($urandom_range(0, 9)) - 1);
            end
            loads.insert($urandom_range(0, loads.size()), it);
        end
        if ($urandom_range(0, 3) == 0)
        begin
            it = make_item(KIND_NONE, $urandom, $urandom, $urandom);
            loads.insert($urandom_range(0, loads.size()), it);
        end
        foreach (loads[i])
            send_item(loads[i]);
        if ($urandom_range(0, 15) != 0)
            send_item(make_item(dpim_pkg::KIND_EVAL, $urandom, $urandom, $urandom));
    endtask

    // response side: random stalls, one long hold-off to back the block up
    initial
    begin
        @(negedge clk);
        forever
        begin
            if (!hold_done && item_count >= HOLD_AFTER)
            begin
                hold_done = 1'b1;
                rsp_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else if (!calm && $urandom_range(0, 6) == 0)
            begin
                rsp_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(negedge clk);
            end
            else
            begin
                rsp_ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(negedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
            board.check_result(rsp);
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("distinct_point_interval_match_top_test NOT OK");
        $finish;
    end

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // empty range set
        send_item(make_item(dpim_pkg::KIND_EVAL, 0, 0, 0));
        // extreme values, full-span range, ignored kind
        send_item(make_item(dpim_pkg::KIND_VALUE, -32768, 0, 0));
        send_item(make_item(dpim_pkg::KIND_VALUE, 32767, 0, 0));
        send_item(make_item(dpim_pkg::KIND_RANGE, 0, -32768, 32767));
        send_item(make_item(KIND_NONE, -1, -1, -1));
        send_item(make_item(dpim_pkg::KIND_EVAL, 0, 0, 0));
        // empty range
        send_item(make_item(dpim_pkg::KIND_VALUE, 5, 0, 0));
        send_item(make_item(dpim_pkg::KIND_RANGE, 0, 5, 5));
        send_item(make_item(dpim_pkg::KIND_EVAL, 0, 0, 0));
        // fewer values than ranges
        send_item(make_item(dpim_pkg::KIND_RANGE, 0, 0, 10));
        send_item(make_item(dpim_pkg::KIND_RANGE, 0, 0, 10));
        send_item(make_item(dpim_pkg::KIND_VALUE, 3, 0, 0));
        send_item(make_item(dpim_pkg::KIND_EVAL, 0, 0, 0));
        // exclusive end
        send_item(make_item(dpim_pkg::KIND_VALUE, 32767, 0, 0));
        send_item(make_item(dpim_pkg::KIND_RANGE, 0, 32766, 32767));
        send_item(make_item(dpim_pkg::KIND_EVAL, 0, 0, 0));
        // inverted range
        send_item(make_item(dpim_pkg::KIND_VALUE, 0, 0, 0));
        send_item(make_item(dpim_pkg::KIND_RANGE, 0, 10, -10));
        send_item(make_item(dpim_pkg::KIND_EVAL, 0, 0, 0));
        // range store overflow
        for (int i = 0; i < 9; i++)
            send_item(make_item(dpim_pkg::KIND_RANGE, 0, -100 + i, 100));
        send_item(make_item(dpim_pkg::KIND_EVAL, 0, 0, 0));

        while (item_count < ITEM_TARGET)
        begin
            if (item_count >= CALM_AFTER)
                calm = 1'b1;
            run_batch();
        end
        @(negedge clk);
        req_valid <= 1'b0;

        while (board.expected_answers.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d load/evaluate items; %0d evaluates, %0d matched, %0d after overflow",
                 item_count, board.evals, board.match_count, board.overflows);
        $display("random stalls on both sides plus a %0d-cycle output hold-off", HOLD_CYCLES);
        if (board.errors == 0)
            $display("distinct_point_interval_match_top_test OK");
        else
            $display("distinct_point_interval_match_top_test NOT OK");
        $finish;
    end
endmodule
